[rtl/tmpe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmpe_pkg
// Shared types and constants of the tour mutation population engine.
// ----------------------------------------------------------------------------
package tmpe_pkg;

  localparam int DEF_CITY_COUNT   = 8;
  localparam int DEF_POP_CAPACITY = 32;

  localparam int CMD_W   = 3;
  localparam int ROAD_W  = 16;
  localparam int LEN_W   = 20;
  localparam int STAT_W  = 2;
  localparam int GEN_W   = 16;
  localparam int TEMP_W  = 14;
  localparam int SIZE_W  = 6;

  localparam logic [ROAD_W-1:0] NO_ROAD     = 16'hFFFF;
  localparam logic [LEN_W-1:0]  UNREACHABLE = 20'hFFFFF;
  localparam logic [TEMP_W-1:0] START_TEMP  = 14'd10000;
  localparam logic [TEMP_W-1:0] COLD_TEMP   = 14'd100;
  localparam logic [GEN_W-1:0]  GEN_MAX     = 16'hFFFF;

  localparam logic [SIZE_W-1:0] RST_POP_SIZE  = 6'd8;
  localparam logic [SIZE_W-1:0] RST_CHILD_CNT = 6'd4;
  localparam logic [GEN_W-1:0]  RST_MAX_GEN   = 16'd100;

  // floor(2^19 / 10), undershoots by less than one for values below 2^17
  localparam logic [15:0] RECIP_TEN = 16'd52428;

  typedef enum logic [CMD_W-1:0] {
    CMD_DIST   = 3'd0,
    CMD_MEMBER = 3'd1,
    CMD_SORT   = 3'd2,
    CMD_MUTATE = 3'd3,
    CMD_COMMIT = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EQUAL = 2'd1,
    STAT_BAD   = 2'd2,
    STAT_DONE  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_POP_SIZE  = 2'd0,
    REG_CHILD_CNT = 2'd1,
    REG_MAX_GEN   = 2'd2
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_PARENT_RD,
    S_PARENT_LAT,
    S_LEN_RD,
    S_LEN_ACC,
    S_LEN_END,
    S_KEY_RD,
    S_KEY_LAT,
    S_CMP_RD,
    S_CMP,
    S_PLACE,
    S_COPY_RD,
    S_COPY_WR,
    S_COOL,
    S_COOL_FIX,
    S_BEST_RD,
    S_BEST_LAT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

[rtl/tmpe_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmpe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/tour_mutation_population_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tour_mutation_population_engine
// Genetic search over closed tours with swap mutation and parent/child merge.
// ----------------------------------------------------------------------------
// One command is taken at a time and answered by one result beat. A distance
// write goes to the distance memory in the decode state. A member load reads
// the distance memory once per road, one road after another; a mutation first
// reads the parent tour and swaps its two positions. Sort and commit rank every
// candidate against every candidate through single-port reads of the member
// and child memories, over the population for a sort and over population size
// plus child count for a commit, then copy the best ranks back to the member
// memory; a commit then cools the temperature. A new result beat waits until
// the previous one has been taken.
module tour_mutation_population_engine
  import tmpe_pkg::*;
#(
  parameter int CITY_COUNT   = DEF_CITY_COUNT,
  parameter int POP_CAPACITY = DEF_POP_CAPACITY
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // cmd, from_city, to_city, road_length, slot, tour_in, pos_a, pos_b
  input  wire  [((3 + 4 * $clog2(CITY_COUNT) + 16 + $clog2(POP_CAPACITY)
               + $clog2(CITY_COUNT) * (CITY_COUNT - 1) + 7) / 8) * 8 - 1:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // status, tour_out, tour_length, finished, generation
  output logic [((2 + $clog2(CITY_COUNT) * (CITY_COUNT - 1) + 20 + 1 + 16 + 7)
               / 8) * 8 - 1:0] m_tdata,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB    = $clog2(CITY_COUNT);
  localparam int TW    = CB * (CITY_COUNT - 1);
  localparam int SW    = $clog2(POP_CAPACITY);
  localparam int AW    = SW;
  localparam int DAW   = $clog2(CITY_COUNT * CITY_COUNT);
  localparam int EW    = TW + LEN_W;
  localparam int CNTW0 = $clog2(2 * POP_CAPACITY) + 1;
  localparam int CNTW  = (CNTW0 > SIZE_W + 1) ? CNTW0 : SIZE_W + 1;
  localparam int SUMW  = LEN_W + 1;

  localparam int O_FROM = CMD_W;
  localparam int O_TO   = O_FROM + CB;
  localparam int O_ROAD = O_TO + CB;
  localparam int O_SLOT = O_ROAD + ROAD_W;
  localparam int O_TOUR = O_SLOT + SW;
  localparam int O_PA   = O_TOUR + TW;
  localparam int O_PB   = O_PA + CB;
  localparam int IN_W   = O_PB + CB;
  localparam int IN_DW  = ((IN_W + 7) / 8) * 8;

  localparam int R_TOUR = STAT_W;
  localparam int R_LEN  = R_TOUR + TW;
  localparam int R_FIN  = R_LEN + LEN_W;
  localparam int R_GEN  = R_FIN + 1;
  localparam int OUT_W  = R_GEN + GEN_W;
  localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

  localparam logic [CB-1:0]   LAST_POS = CB'(CITY_COUNT - 1);
  localparam logic [CNTW-1:0] POP_CAP  = CNTW'(POP_CAPACITY);

  state_t state_r, state_next;

  logic [CMD_W-1:0]   cmd_r;
  logic [CB-1:0]      from_r, to_r, pa_r, pb_r;
  logic [ROAD_W-1:0]  road_r;
  logic [SW-1:0]      slot_r;
  logic [TW-1:0]      tour_in_r;

  logic [SIZE_W-1:0]  pop_size_r, child_cnt_r;
  logic [GEN_W-1:0]   max_gen_r, gen_r;
  logic [TEMP_W-1:0]  temp_r;
  logic [POP_CAPACITY-1:0] written_r;

  logic [TW-1:0]      work_tour_r;
  logic [LEN_W-1:0]   parent_len_r;
  logic [CB-1:0]      pos_r;
  logic [SUMW-1:0]    sum_r;
  logic               unreach_r, bad_r;

  logic [CNTW-1:0]    cand_n_r, i_r, j_r, rank_r, ci_r;
  logic [EW-1:0]      key_r;
  logic               sel_r;
  logic [16:0]        x_r;
  logic [TEMP_W:0]    q0_r;

  logic [STAT_W-1:0]  res_status_r;
  logic [TW-1:0]      res_tour_r;
  logic [LEN_W-1:0]   res_len_r;

  logic               m_tvalid_r;
  logic [OUT_DW-1:0]  m_tdata_r;

  // memory ports
  logic               dist_we, mem_we, child_we, sort_we;
  logic [DAW-1:0]     dist_waddr, dist_raddr;
  logic [ROAD_W-1:0]  dist_rdata;
  logic [AW-1:0]      mem_waddr, mem_raddr, child_waddr, child_raddr;
  logic [AW-1:0]      sort_waddr, sort_raddr;
  logic [EW-1:0]      mem_wdata, mem_rdata, child_wdata, child_rdata;
  logic [EW-1:0]      sort_wdata, sort_rdata;
  logic [CNTW-1:0]    rd_idx, rd_child_idx;

  // derived values
  logic [CNTW-1:0]    pop_n, child_n;
  logic               finished;
  logic [POP_CAPACITY-1:0] need_mask;
  logic               all_written;
  logic               slot_bad_member, slot_bad_child, pos_bad;
  logic [CB-1:0]      city_a, city_b, pos_nx;
  logic [TW-1:0]      swapped;
  logic [CB-1:0]      cap, cbp;
  logic [LEN_W-1:0]   len_final, child_len;
  logic [EW-1:0]      cand;
  logic               cand_less;
  logic               cfg_wr;
  logic [16:0]        x_next;
  logic [33:0]        prod;
  logic [16:0]        rem;

  assign pready   = 1'b1;
  assign s_tready = (state_r == S_IDLE);
  assign m_tvalid = m_tvalid_r;
  assign m_tdata  = m_tdata_r;
  assign cfg_wr   = psel & penable & pwrite & pready;

  assign pop_n   = (CNTW'(pop_size_r) > POP_CAP) ? POP_CAP : CNTW'(pop_size_r);
  assign child_n = (CNTW'(child_cnt_r) > pop_n) ? pop_n : CNTW'(child_cnt_r);
  assign finished = (temp_r <= COLD_TEMP) || (gen_r > max_gen_r);

  for (genvar g = 0; g < POP_CAPACITY; g++) begin : g_need
    assign need_mask[g] = (CNTW'(g) < child_n);
  end
  assign all_written = &(written_r | ~need_mask);

  assign slot_bad_member = (CNTW'(slot_r) >= pop_n);
  assign slot_bad_child  = (CNTW'(slot_r) >= child_n);
  assign pos_bad = (pa_r == '0) || (pb_r == '0) ||
                   (32'(pa_r) >= CITY_COUNT) || (32'(pb_r) >= CITY_COUNT);

  // swap two positions of the parent tour
  assign cap = mem_rdata[LEN_W + 32'(pa_r - CB'(1)) * CB +: CB];
  assign cbp = mem_rdata[LEN_W + 32'(pb_r - CB'(1)) * CB +: CB];
  for (genvar q = 1; q < CITY_COUNT; q++) begin : g_swap
    assign swapped[(q-1)*CB +: CB] = (pa_r == CB'(q)) ? cbp :
                                     (pb_r == CB'(q)) ? cap :
                                     mem_rdata[LEN_W + (q-1)*CB +: CB];
  end

  // cities at both ends of the current road
  assign pos_nx = (pos_r == LAST_POS) ? '0 : pos_r + CB'(1);
  assign city_a = (pos_r == '0) ? '0 : work_tour_r[32'(pos_r - CB'(1)) * CB +: CB];
  assign city_b = (pos_nx == '0) ? '0 : work_tour_r[32'(pos_nx - CB'(1)) * CB +: CB];

  assign len_final = unreach_r ? UNREACHABLE :
                     (sum_r > SUMW'(UNREACHABLE)) ? UNREACHABLE : sum_r[LEN_W-1:0];
  assign child_len = (len_final > parent_len_r) ? UNREACHABLE : len_final;

  assign cand = sel_r ? child_rdata : mem_rdata;
  assign cand_less = (cand[LEN_W-1:0] < key_r[LEN_W-1:0]) ||
                     ((cand[LEN_W-1:0] == key_r[LEN_W-1:0]) && (j_r < i_r));

  assign x_next = (17'(temp_r) << 3) + 17'(temp_r);
  assign prod   = 34'(x_next) * 34'(RECIP_TEN);
  assign rem    = x_r - ((17'(q0_r) << 3) + (17'(q0_r) << 1));

  // ---------------------------------------------------------------------------
  // memories
  // ---------------------------------------------------------------------------
  tmpe_ram #(.WIDTH(ROAD_W), .DEPTH(CITY_COUNT * CITY_COUNT)) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(road_r),
    .raddr(dist_raddr), .rdata(dist_rdata)
  );

  tmpe_ram #(.WIDTH(EW), .DEPTH(POP_CAPACITY)) u_member (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  tmpe_ram #(.WIDTH(EW), .DEPTH(POP_CAPACITY)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  tmpe_ram #(.WIDTH(EW), .DEPTH(POP_CAPACITY)) u_sorted (
    .clk(clk), .we(sort_we), .waddr(sort_waddr), .wdata(sort_wdata),
    .raddr(sort_raddr), .rdata(sort_rdata)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state_r;
    case (state_r)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (cmd_r)
          CMD_MEMBER: state_next = slot_bad_member ? S_DONE : S_LEN_RD;
          CMD_SORT:   state_next = (pop_n == '0) ? S_BEST_RD : S_KEY_RD;
          CMD_MUTATE: begin
            if (finished) begin
              state_next = S_BEST_RD;
            end else if (slot_bad_child || pos_bad || (pa_r == pb_r)) begin
              state_next = S_DONE;
            end else begin
              state_next = S_PARENT_RD;
            end
          end
          CMD_COMMIT: begin
            if (finished || !all_written) begin
              state_next = S_BEST_RD;
            end else begin
              state_next = (pop_n == '0) ? S_COOL : S_KEY_RD;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_PARENT_RD:  state_next = S_PARENT_LAT;
      S_PARENT_LAT: state_next = S_LEN_RD;
      S_LEN_RD:     state_next = S_LEN_ACC;
      S_LEN_ACC:    state_next = (pos_r == LAST_POS) ? S_LEN_END : S_LEN_RD;
      S_LEN_END:    state_next = S_DONE;
      S_KEY_RD:     state_next = S_KEY_LAT;
      S_KEY_LAT:    state_next = S_CMP_RD;
      S_CMP_RD:     state_next = S_CMP;
      S_CMP:        state_next = (j_r == cand_n_r - CNTW'(1)) ? S_PLACE : S_CMP_RD;
      S_PLACE:      state_next = (i_r == cand_n_r - CNTW'(1)) ? S_COPY_RD : S_KEY_RD;
      S_COPY_RD:    state_next = S_COPY_WR;
      S_COPY_WR: begin
        if (ci_r == pop_n - CNTW'(1)) begin
          state_next = (cmd_r == CMD_COMMIT) ? S_COOL : S_BEST_RD;
        end else begin
          state_next = S_COPY_RD;
        end
      end
      S_COOL:       state_next = S_COOL_FIX;
      S_COOL_FIX:   state_next = S_BEST_RD;
      S_BEST_RD:    state_next = S_BEST_LAT;
      S_BEST_LAT:   state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid_r || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default:      state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // memory control
  // ---------------------------------------------------------------------------
  always_comb begin
    dist_we     = 1'b0;
    dist_waddr  = DAW'(32'(from_r) * CITY_COUNT + 32'(to_r));
    dist_raddr  = DAW'(32'(city_a) * CITY_COUNT + 32'(city_b));
    mem_we      = 1'b0;
    mem_waddr   = slot_r;
    mem_wdata   = {work_tour_r, len_final};
    child_we    = 1'b0;
    child_waddr = slot_r;
    child_wdata = {work_tour_r, child_len};
    sort_we     = 1'b0;
    sort_waddr  = rank_r[AW-1:0];
    sort_wdata  = key_r;
    sort_raddr  = ci_r[AW-1:0];
    rd_idx      = (state_r == S_KEY_RD) ? i_r : j_r;
    rd_child_idx = rd_idx - pop_n;
    mem_raddr   = rd_idx[AW-1:0];
    child_raddr = rd_child_idx[AW-1:0];
    case (state_r)
      S_DECODE: begin
        dist_we = (cmd_r == CMD_DIST) && (32'(from_r) < CITY_COUNT) &&
                  (32'(to_r) < CITY_COUNT);
      end
      S_PARENT_RD: mem_raddr = slot_r;
      S_LEN_END: begin
        mem_we   = (cmd_r == CMD_MEMBER);
        child_we = (cmd_r == CMD_MUTATE);
      end
      S_PLACE: sort_we = (rank_r < pop_n);
      S_COPY_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ci_r[AW-1:0];
        mem_wdata = sort_rdata;
      end
      S_BEST_RD: mem_raddr = '0;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state_r     <= S_IDLE;
      pop_size_r  <= RST_POP_SIZE;
      child_cnt_r <= RST_CHILD_CNT;
      max_gen_r   <= RST_MAX_GEN;
      temp_r      <= START_TEMP;
      gen_r       <= GEN_W'(1);
      written_r   <= '0;
      m_tvalid_r  <= 1'b0;
    end else begin
      state_r <= state_next;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_POP_SIZE:  pop_size_r  <= pwdata[SIZE_W-1:0];
          REG_CHILD_CNT: child_cnt_r <= pwdata[SIZE_W-1:0];
          REG_MAX_GEN:   max_gen_r   <= pwdata[GEN_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_DECODE && cmd_r == CMD_SORT) begin
        temp_r    <= START_TEMP;
        gen_r     <= GEN_W'(1);
        written_r <= '0;
      end
      if (state_r == S_LEN_END && cmd_r == CMD_MUTATE) begin
        written_r[slot_r] <= 1'b1;
      end
      if (state_r == S_COOL_FIX) begin
        temp_r    <= (rem >= 17'd10) ? TEMP_W'(q0_r + 1'b1) : q0_r[TEMP_W-1:0];
        gen_r     <= (gen_r == GEN_MAX) ? gen_r : gen_r + GEN_W'(1);
        written_r <= '0;
      end
      if (state_r == S_DONE && (!m_tvalid_r || m_tready)) begin
        m_tvalid_r <= 1'b1;
      end else if (m_tvalid_r && m_tready) begin
        m_tvalid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        cmd_r     <= s_tdata[CMD_W-1:0];
        from_r    <= s_tdata[O_FROM +: CB];
        to_r      <= s_tdata[O_TO +: CB];
        road_r    <= s_tdata[O_ROAD +: ROAD_W];
        slot_r    <= s_tdata[O_SLOT +: SW];
        tour_in_r <= s_tdata[O_TOUR +: TW];
        pa_r      <= s_tdata[O_PA +: CB];
        pb_r      <= s_tdata[O_PB +: CB];
      end
      S_DECODE: begin
        res_tour_r   <= '0;
        res_len_r    <= '0;
        res_status_r <= STAT_OK;
        work_tour_r  <= tour_in_r;
        pos_r        <= '0;
        sum_r        <= '0;
        unreach_r    <= 1'b0;
        i_r          <= '0;
        ci_r         <= '0;
        cand_n_r     <= (cmd_r == CMD_COMMIT) ? pop_n + child_n : pop_n;
        case (cmd_r)
          CMD_DIST:   res_len_r <= LEN_W'(road_r);
          CMD_MEMBER: begin
            if (slot_bad_member) begin
              res_status_r <= STAT_BAD;
            end
          end
          CMD_SORT: begin
            if (max_gen_r == '0) begin
              res_status_r <= STAT_DONE;
            end
          end
          CMD_MUTATE: begin
            if (finished) begin
              res_status_r <= STAT_DONE;
            end else if (slot_bad_child || pos_bad) begin
              res_status_r <= STAT_BAD;
            end else if (pa_r == pb_r) begin
              res_status_r <= STAT_EQUAL;
            end
          end
          CMD_COMMIT: begin
            if (finished) begin
              res_status_r <= STAT_DONE;
            end else if (!all_written) begin
              res_status_r <= STAT_BAD;
            end
          end
          default: ;
        endcase
      end
      S_PARENT_LAT: begin
        work_tour_r  <= swapped;
        parent_len_r <= mem_rdata[LEN_W-1:0];
      end
      S_LEN_RD: begin
        bad_r <= (32'(city_a) >= CITY_COUNT) || (32'(city_b) >= CITY_COUNT);
      end
      S_LEN_ACC: begin
        if (bad_r || dist_rdata == NO_ROAD) begin
          unreach_r <= 1'b1;
        end
        sum_r <= sum_r + SUMW'(dist_rdata);
        pos_r <= pos_nx;
      end
      S_LEN_END: begin
        res_tour_r <= work_tour_r;
        res_len_r  <= (cmd_r == CMD_MUTATE) ? child_len : len_final;
      end
      S_KEY_RD: sel_r <= (i_r >= pop_n);
      S_KEY_LAT: begin
        key_r  <= cand;
        rank_r <= '0;
        j_r    <= '0;
      end
      S_CMP_RD: sel_r <= (j_r >= pop_n);
      S_CMP: begin
        if (cand_less) begin
          rank_r <= rank_r + CNTW'(1);
        end
        j_r <= j_r + CNTW'(1);
      end
      S_PLACE:   i_r  <= i_r + CNTW'(1);
      S_COPY_WR: ci_r <= ci_r + CNTW'(1);
      S_COOL: begin
        x_r  <= x_next;
        q0_r <= prod[33:19];
      end
      S_BEST_LAT: begin
        if (pop_n != '0) begin
          res_tour_r <= mem_rdata[EW-1:LEN_W];
          res_len_r  <= mem_rdata[LEN_W-1:0];
        end
      end
      S_DONE: begin
        if (!m_tvalid_r || m_tready) begin
          m_tdata_r <= OUT_DW'({gen_r, finished, res_len_r, res_tour_r, res_status_r});
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // register readback
  // ---------------------------------------------------------------------------
  always_comb begin
    case (paddr[3:2])
      REG_POP_SIZE:  prdata = 32'(pop_size_r);
      REG_CHILD_CNT: prdata = 32'(child_cnt_r);
      REG_MAX_GEN:   prdata = 32'(max_gen_r);
      default:       prdata = '0;
    endcase
  end

`ifndef ASSERT_OFF
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst) gen_r != '0)
    else $error("generation count reached zero");

  a_child_slot: assert property (@(posedge clk) disable iff (rst)
    child_we |-> (CNTW'(child_waddr) < child_n))
    else $error("child written beyond child count");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    sort_we |-> (rank_r < cand_n_r))
    else $error("rank beyond candidate count");

  a_cool_once: assert property (@(posedge clk) disable iff (rst)
    (state_r == S_COOL_FIX) |=> (temp_r <= $past(temp_r)))
    else $error("temperature rose on commit");
`endif

endmodule
`default_nettype wire
